>>> rtl/v3alu_pkg.sv
// Package for the three-component fixed-point vector ALU.
// Holds the operation codes, shared types and the saturation helper.
// No dependencies.
package v3alu_pkg;

  localparam int CompW = 32;
  localparam int ProdW = 66;
  localparam int WideW = 68;
  localparam int CodeW = 6;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_CROSS    = 4'd2,
    OP_DOT      = 4'd3,
    OP_SCALE    = 4'd4,
    OP_MIRROR   = 4'd5,
    OP_MARGIN   = 4'd6,
    OP_OCTANT   = 4'd7,
    OP_SIGNMASK = 4'd8,
    OP_EQUAL    = 4'd9
  } op_t;

  typedef struct packed {
    logic              ovf;
    logic [CompW-1:0]  val;
  } sat_t;

  typedef struct packed {
    logic              mir;
    logic              ovf;
    logic [CodeW-1:0]  code;
  } mstat_t;

  function automatic sat_t sat_w(input wide_t v);
    sat_t res;
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WideW-1:CompW-1];
    hi_zeros = ~|v[WideW-1:CompW-1];
    res.ovf  = !(hi_ones || hi_zeros);
    if (res.ovf) begin
      res.val = v[WideW-1] ? {1'b1, {(CompW-1){1'b0}}} : {1'b0, {(CompW-1){1'b1}}};
    end else begin
      res.val = v[CompW-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/v3alu_lane.sv
// One product lane: forms the two registered products that an operation
// needs for one vector component. Depends on v3alu_pkg.
module v3alu_lane (
  input  logic             clk,
  input  logic             en,
  input  v3alu_pkg::op_t   op,
  input  v3alu_pkg::comp_t ai,
  input  v3alu_pkg::comp_t bi,
  input  v3alu_pkg::comp_t aj,
  input  v3alu_pkg::comp_t bj,
  input  v3alu_pkg::comp_t ak,
  input  v3alu_pkg::comp_t bk,
  input  v3alu_pkg::comp_t s,
  output v3alu_pkg::prod_t m0_o,
  output v3alu_pkg::prod_t m1_o
);
  import v3alu_pkg::*;

  logic signed [CompW:0] x0, y0, x1, y1, d;
  prod_t m0_r, m1_r;

  assign d = (CompW+1)'(ai) - (CompW+1)'(bi);

  always_comb begin
    x0 = '0;
    y0 = '0;
    x1 = '0;
    y1 = '0;
    case (op)
      OP_CROSS: begin
        x0 = (CompW+1)'(aj);
        y0 = (CompW+1)'(bk);
        x1 = (CompW+1)'(ak);
        y1 = (CompW+1)'(bj);
      end
      OP_DOT, OP_MIRROR: begin
        x0 = (CompW+1)'(ai);
        y0 = (CompW+1)'(bi);
      end
      OP_SCALE: begin
        x0 = (CompW+1)'(ai);
        y0 = (CompW+1)'(s);
      end
      OP_MARGIN: begin
        x0 = d;
        y0 = d;
        x1 = (CompW+1)'(s);
        y1 = (CompW+1)'(s);
      end
      default: begin
        x0 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= x0 * y0;
      m1_r <= x1 * y1;
    end
  end

  assign m0_o = m0_r;
  assign m1_o = m1_r;

endmodule

>>> rtl/v3alu_merge.sv
// Merging stage: combines the lane products into saturated results,
// flag codes and the mirror dot product. Depends on v3alu_pkg.
module v3alu_merge #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  v3alu_pkg::op_t     op,
  input  v3alu_pkg::comp_t   a [3],
  input  v3alu_pkg::comp_t   b [3],
  input  v3alu_pkg::comp_t   s,
  input  v3alu_pkg::prod_t   m0 [3],
  input  v3alu_pkg::prod_t   m1 [3],
  output v3alu_pkg::comp_t   r_o [3],
  output v3alu_pkg::comp_t   t_o,
  output v3alu_pkg::mstat_t  st_o
);
  import v3alu_pkg::*;

  wide_t  dsum;
  sat_t   dsat;
  sat_t   ls [3];
  comp_t  r_nxt [3];
  comp_t  r_r [3];
  comp_t  t_r;
  mstat_t st_nxt, st_r;
  logic signed [CompW:0] neg_s;

  assign dsum  = WideW'(m0[0]) + WideW'(m0[1]) + WideW'(m0[2]);
  assign dsat  = sat_w(dsum >>> FRACTION_BITS);
  assign neg_s = -((CompW+1)'(s));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ls[i] = '0;
      case (op)
        OP_ADD:   ls[i] = sat_w(WideW'(a[i]) + WideW'(b[i]));
        OP_SUB:   ls[i] = sat_w(WideW'(a[i]) - WideW'(b[i]));
        OP_CROSS: ls[i] = sat_w((WideW'(m0[i]) - WideW'(m1[i])) >>> FRACTION_BITS);
        OP_SCALE: ls[i] = sat_w(WideW'(m0[i]) >>> FRACTION_BITS);
        OP_DOT:   ls[i] = (i == 0) ? dsat : '0;
        default:  ls[i] = '0;
      endcase
      r_nxt[i] = ls[i].val;
    end
  end

  always_comb begin
    st_nxt      = '0;
    st_nxt.ovf  = ls[0].ovf | ls[1].ovf | ls[2].ovf;
    case (op)
      OP_MIRROR: begin
        st_nxt.mir = 1'b1;
        st_nxt.ovf = dsat.ovf;
      end
      OP_MARGIN: begin
        st_nxt.code = {5'd0, (dsum <= WideW'(m1[0]))};
      end
      OP_OCTANT: begin
        st_nxt.code = {3'd0, ~a[0][CompW-1], ~a[1][CompW-1], ~a[2][CompW-1]};
      end
      OP_SIGNMASK: begin
        for (int i = 0; i < 3; i++) begin
          st_nxt.code[5-i] = (CompW+1)'(a[i]) > neg_s;
          st_nxt.code[2-i] = (CompW+1)'(a[i]) < (CompW+1)'(s);
        end
      end
      OP_EQUAL: begin
        st_nxt.code = {5'd0, (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2])};
      end
      default: begin
        st_nxt.mir = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r  <= r_nxt;
      t_r  <= dsat.val;
      st_r <= st_nxt;
    end
  end

  assign r_o  = r_r;
  assign t_o  = t_r;
  assign st_o = st_r;

endmodule

>>> rtl/v3alu_refl.sv
// Mirror lane: multiplies the normal component by the saturated dot
// product and forms the reflected component. Depends on v3alu_pkg.
module v3alu_refl #(
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic             mir,
  input  v3alu_pkg::comp_t ai,
  input  v3alu_pkg::comp_t bi,
  input  v3alu_pkg::comp_t t,
  input  v3alu_pkg::comp_t r_in,
  output v3alu_pkg::comp_t res_o,
  output logic             ovf_o
);
  import v3alu_pkg::*;

  logic signed [2*CompW-1:0] p_r;
  comp_t a_r, r_r;
  logic  mir_r;
  wide_t q;
  sat_t  v;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= bi * t;
      a_r   <= ai;
      r_r   <= r_in;
      mir_r <= mir;
    end
  end

  assign q     = WideW'(p_r) >>> FRACTION_BITS;
  assign v     = sat_w(WideW'(a_r) - (q <<< 1));
  assign res_o = mir_r ? comp_t'(v.val) : r_r;
  assign ovf_o = mir_r & v.ovf;

endmodule

>>> rtl/vec3_fixed_point_alu.sv
// Top level of the three-component fixed-point vector ALU.
// Uses v3alu_pkg, v3alu_lane, v3alu_merge and v3alu_refl.
//
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  operation, ax..az, bx..bz, scalar
// out_     output     out_valid / out_stall rx, ry, rz, code, overflow
//
// One beat is accepted per cycle while in_stall is low.
// The four stages are lane products, merge, mirror product and output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the stage valid bits only.
module vec3_fixed_point_alu #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [3:0]                in_operation,
  input  logic signed [31:0]        in_ax,
  input  logic signed [31:0]        in_ay,
  input  logic signed [31:0]        in_az,
  input  logic signed [31:0]        in_bx,
  input  logic signed [31:0]        in_by,
  input  logic signed [31:0]        in_bz,
  input  logic signed [31:0]        in_scalar,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_rx,
  output logic signed [31:0]        out_ry,
  output logic signed [31:0]        out_rz,
  output logic [5:0]                out_code,
  output logic                      out_overflow
);
  import v3alu_pkg::*;

  logic   adv;
  logic   v1_r, v2_r, v3_r, out_valid_r;
  op_t    op_in, op1_r;
  comp_t  ain [3];
  comp_t  bin [3];
  comp_t  a1_r [3];
  comp_t  b1_r [3];
  comp_t  s1_r;
  comp_t  a2_r [3];
  comp_t  b2_r [3];
  prod_t  m0 [3];
  prod_t  m1 [3];
  comp_t  rm [3];
  comp_t  tm;
  mstat_t stm, st3_r;
  comp_t  rf [3];
  logic   of [3];
  comp_t  rx_r, ry_r, rz_r;
  logic [CodeW-1:0] code_r;
  logic   ovf_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign op_in    = op_t'(in_operation);

  assign ain[0] = in_ax;
  assign ain[1] = in_ay;
  assign ain[2] = in_az;
  assign bin[0] = in_bx;
  assign bin[1] = in_by;
  assign bin[2] = in_bz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .op   (op_in),
      .ai   (ain[i]),
      .bi   (bin[i]),
      .aj   (ain[(i+1)%3]),
      .bj   (bin[(i+1)%3]),
      .ak   (ain[(i+2)%3]),
      .bk   (bin[(i+2)%3]),
      .s    (in_scalar),
      .m0_o (m0[i]),
      .m1_o (m1[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= op_in;
      a1_r  <= ain;
      b1_r  <= bin;
      s1_r  <= in_scalar;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      st3_r <= stm;
    end
  end

  v3alu_merge #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_merge (
    .clk  (clk),
    .en   (adv),
    .op   (op1_r),
    .a    (a1_r),
    .b    (b1_r),
    .s    (s1_r),
    .m0   (m0),
    .m1   (m1),
    .r_o  (rm),
    .t_o  (tm),
    .st_o (stm)
  );

  for (genvar i = 0; i < 3; i++) begin : g_refl
    v3alu_refl #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_refl (
      .clk   (clk),
      .en    (adv),
      .mir   (stm.mir),
      .ai    (a2_r[i]),
      .bi    (b2_r[i]),
      .t     (tm),
      .r_in  (rm[i]),
      .res_o (rf[i]),
      .ovf_o (of[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r   <= rf[0];
      ry_r   <= rf[1];
      rz_r   <= rf[2];
      code_r <= st3_r.code;
      ovf_r  <= st3_r.ovf | of[0] | of[1] | of[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rx       = rx_r;
  assign out_ry       = ry_r;
  assign out_rz       = rz_r;
  assign out_code     = code_r;
  assign out_overflow = ovf_r;

endmodule

>>> tb/sv/vec3_fixed_point_alu_tb.sv
// Self-checking testbench for the three-component fixed-point vector ALU.
// Drives random and directed beats and checks each result against a predictor.
// Depends on v3alu_pkg and vec3_fixed_point_alu.
module vec3_fixed_point_alu_tb;
  import v3alu_pkg::*;

  localparam int Frac = 16;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic signed [31:0] s;
  } beat_t;

  typedef struct {
    logic signed [31:0] r [3];
    logic [5:0]         code;
    logic               ovf;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_operation = '0;
  logic signed [31:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [31:0] in_bx = '0, in_by = '0, in_bz = '0, in_scalar = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_rx, out_ry, out_rz;
  logic [5:0] out_code;
  logic out_overflow;

  beat_t pending_beats [$];
  res_t expected_results [$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_ovf = 0;
  bit gaps_on = 1'b1;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  vec3_fixed_point_alu #(.FRACTION_BITS(Frac)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz), .in_scalar(in_scalar),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_code(out_code), .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic res_t compute_alu(input beat_t x);
    res_t o;
    logic signed [127:0] a [3];
    logic signed [127:0] b [3];
    logic signed [127:0] s, w, t, d, tot;
    logic far;
    int j, k;
    o.r = '{0, 0, 0};
    o.code = '0;
    o.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = x.a[i];
      b[i] = x.b[i];
    end
    s = x.s;
    case (x.op)
      OP_ADD: for (int i = 0; i < 3; i++) o.r[i] = clamp32(a[i] + b[i], o.ovf);
      OP_SUB: for (int i = 0; i < 3; i++) o.r[i] = clamp32(a[i] - b[i], o.ovf);
      OP_CROSS: for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        w = a[j] * b[k] - a[k] * b[j];
        o.r[i] = clamp32(w >>> Frac, o.ovf);
      end
      OP_DOT: begin
        w = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        o.r[0] = clamp32(w >>> Frac, o.ovf);
      end
      OP_SCALE: for (int i = 0; i < 3; i++) o.r[i] = clamp32((a[i] * s) >>> Frac, o.ovf);
      OP_MIRROR: begin
        w = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        t = clamp32(w >>> Frac, o.ovf);
        for (int i = 0; i < 3; i++)
          o.r[i] = clamp32(a[i] - 2 * ((b[i] * t) >>> Frac), o.ovf);
      end
      OP_MARGIN: begin
        far = 1'b0;
        tot = 0;
        for (int i = 0; i < 3; i++) begin
          d = (a[i] - b[i]) * (a[i] - b[i]);
          if (d > (128'sd1 <<< 62)) far = 1'b1;
          else tot = tot + d;
        end
        // The squared margin wraps at 64 bits unsigned.
        d = s * s;
        d = {64'd0, d[63:0]};
        o.code = (!far && tot <= d) ? 6'd1 : 6'd0;
      end
      OP_OCTANT: o.code = {3'b0, x.a[0] >= 0, x.a[1] >= 0, x.a[2] >= 0};
      OP_SIGNMASK: for (int i = 0; i < 3; i++) begin
        if (a[i] < s) o.code[2-i] = 1'b1;
        if (a[i] > -s) o.code[5-i] = 1'b1;
      end
      OP_EQUAL: o.code = (x.a[0] == x.b[0] && x.a[1] == x.b[1] && x.a[2] == x.b[2])
                         ? 6'd1 : 6'd0;
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 131072)) - 65536;
      3: return $signed($urandom_range(0, 16777215)) - 8388608;
      4: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_beat(input logic [3:0] op, input logic signed [31:0] ax,
                           ay, az, bx, by, bz, sc);
    beat_t x;
    x.op = op;
    x.a = '{ax, ay, az};
    x.b = '{bx, by, bz};
    x.s = sc;
    pending_beats.push_back(x);
  endtask

  // The beat on the bus stays at the head of the queue until it is accepted.
  always @(posedge clk) begin
    beat_t x;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compute_alu(pending_beats.pop_front()));
        n_sent <= n_sent + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_beats.size() > 0 && !hold_off
            && !(gaps_on && $urandom_range(0, 99) < 6)) begin
          x = pending_beats[0];
          in_valid <= 1'b1;
          in_operation <= x.op;
          {in_ax, in_ay, in_az} <= {x.a[0], x.a[1], x.a[2]};
          {in_bx, in_by, in_bz} <= {x.b[0], x.b[1], x.b[2]};
          in_scalar <= x.s;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_checked <= n_checked + 1;
      if (expected_results.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result beat rx=%h", out_rx);
      end else begin
        e = expected_results.pop_front();
        if (e.ovf) n_ovf <= n_ovf + 1;
        if (out_rx !== e.r[0] || out_ry !== e.r[1] || out_rz !== e.r[2]
            || out_code !== e.code || out_overflow !== e.ovf) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: exp %h %h %h code %h ovf %b, got %h %h %h code %h ovf %b",
                     e.r[0], e.r[1], e.r[2], e.code, e.ovf,
                     out_rx, out_ry, out_rz, out_code, out_overflow);
        end
      end
    end
  end

  initial begin
    logic signed [31:0] u;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    u = 32'sh00010000;
    push_beat(OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, 1, -1, 2, 0);
    push_beat(OP_SUB, 32'sh80000000, 32'sh7fffffff, 5, 1, -1, 7, 0);
    push_beat(OP_CROSS, u, 0, 0, 0, u, 0, 0);
    push_beat(OP_CROSS, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0);
    push_beat(OP_DOT, -1, -1, -1, 1, 1, 1, 0);
    push_beat(OP_DOT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    push_beat(OP_SCALE, 3 * u, -u, 32'sh7fffffff, 0, 0, 0, 32'sh80000000);
    push_beat(OP_MIRROR, u, -u, 2 * u, 0, 0, u, 0);
    push_beat(OP_MIRROR, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    push_beat(OP_MARGIN, 3 * u, 4 * u, 0, 0, 0, 0, 5 * u);
    push_beat(OP_MARGIN, 3 * u, 4 * u, 0, 0, 0, 0, -5 * u + 1);
    push_beat(OP_MARGIN, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 32'sh80000000);
    push_beat(OP_OCTANT, 0, -1, 32'sh7fffffff, 0, 0, 0, 0);
    push_beat(OP_OCTANT, 32'sh80000000, 0, -1, 0, 0, 0, 0);
    push_beat(OP_SIGNMASK, 0, 1, -1, 0, 0, 0, 1);
    push_beat(OP_SIGNMASK, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 32'sh80000000);
    push_beat(OP_EQUAL, 1, 2, 3, 1, 2, 3, 0);
    push_beat(OP_EQUAL, 1, 2, 3, 1, 2, 4, 0);
    push_beat(4'd10, 1, 2, 3, 4, 5, 6, 7);
    push_beat(4'd15, -1, -1, -1, -1, -1, -1, -1);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < 700; i++) begin
      logic signed [31:0] c [7];
      logic [3:0] op;
      for (int k = 0; k < 7; k++) c[k] = pick_comp();
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      if (op == OP_EQUAL && $urandom_range(0, 1)) begin
        c[3] = c[0];
        c[4] = c[1];
        c[5] = c[2];
      end
      if (i == 200) gaps_on = 1'b0;
      if (i == 350) gaps_on = 1'b1;
      if (i == 500) begin
        hold_off = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
        hold_off = 1'b0;
      end
      while (pending_beats.size() > 8) @(posedge clk);
      push_beat(op, c[0], c[1], c[2], c[3], c[4], c[5], c[6]);
    end
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d beats over all ten operations and unused codes; checked %0d results.",
             n_sent, n_checked);
    $display("%0d results saturated, %0d beats left unmatched.", n_ovf,
             expected_results.size());
    if (errors == 0 && expected_results.size() == 0) begin
      $display("vec3_fixed_point_alu test passed");
    end else begin
      $display("vec3_fixed_point_alu test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vec3_fixed_point_alu test failed");
    $finish;
  end

endmodule
